// ===== design/qeqd_pkg.sv =====
// Shared constants, types and the transition lookup for the quadrature decoder.
// Used by qeqd_ctrl, qeqd_datapath and quadrature_encoder_queue_decoder_core.
package qeqd_pkg;

  // Queue and counter geometry
  localparam int QUEUE_BITS = 64;
  localparam int HOLD_WIDTH = 16;
  localparam int CNT_W      = $clog2(QUEUE_BITS + 1);
  localparam int WIN_W      = $clog2(QUEUE_BITS / 2);
  localparam int ACC_W      = 8;
  localparam int DELTA_W    = 6;
  localparam int HOLD_OUT_W = 16;

  localparam logic [1:0] REST_PAIR = 2'b11;

  // Transition table, indexed by {old B,A, new B,A}
  localparam logic signed [1:0] STEP_TABLE [16] = '{
    2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
    -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
  };

  function automatic logic signed [1:0] step_lut(input logic [3:0] win);
    return STEP_TABLE[win];
  endfunction

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture a request, update the button tracker
    logic step;     // process one window
    logic publish;  // move the frame result into the output register
  } qeqd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk_done;  // no windows left in this frame
  } qeqd_status_t;

endpackage

// ===== design/qeqd_ctrl.sv =====
// Frame sequencer for the quadrature decoder: accept, walk windows, publish.
// Depends on qeqd_pkg for the command and status structs.
module qeqd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  qeqd_pkg::qeqd_status_t status,
  output qeqd_pkg::qeqd_cmd_t   cmd
);
  import qeqd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_POST
  } state_t;

  state_t state;
  logic   out_free;
  logic   out_take;

  // Output register is free when empty or being drained this cycle
  assign out_take = out_valid && !out_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Decode commands from state
  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: cmd.load = in_valid;
      S_WALK: begin
        cmd.step    = !status.walk_done;
        cmd.publish = status.walk_done && out_free;
      end
      S_POST: cmd.publish = out_free;
      default: cmd = '0;
    endcase
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_WALK;
        end
        S_WALK: begin
          if (status.walk_done) state <= out_free ? S_IDLE : S_POST;
        end
        S_POST: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/qeqd_datapath.sv =====
// Datapath of the quadrature decoder: aligned sample queue, accumulator,
// frame delta, button tracker and output register. Depends on qeqd_pkg.
module qeqd_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  qeqd_pkg::qeqd_cmd_t                  cmd,
  output qeqd_pkg::qeqd_status_t               status,
  input  logic [qeqd_pkg::QUEUE_BITS-1:0]      sample_queue,
  input  logic [qeqd_pkg::CNT_W-1:0]           valid_bits,
  input  logic                                 push_level,
  output logic signed [qeqd_pkg::DELTA_W-1:0]  detent_delta,
  output logic                                 push_now,
  output logic                                 push_before,
  output logic [qeqd_pkg::HOLD_OUT_W-1:0]      hold_frames,
  output logic [qeqd_pkg::HOLD_OUT_W-1:0]      prior_hold_frames
);
  import qeqd_pkg::*;

  logic [QUEUE_BITS-1:0]        queue;
  logic [WIN_W-1:0]             windows;
  logic signed [ACC_W-1:0]      acc;
  logic signed [DELTA_W-1:0]    delta;
  logic                         level_reg;
  logic                         prior_level_reg;
  logic [HOLD_WIDTH-1:0]        hold_counter;
  logic [HOLD_WIDTH-1:0]        prior_hold_counter;

  logic [CNT_W-1:0]             cnt;
  logic [CNT_W-1:0]             cnt_half;
  logic [WIN_W-1:0]             windows_next;
  logic [QUEUE_BITS-1:0]        queue_next;
  logic [3:0]                   win;
  logic signed [ACC_W:0]        acc_sum;
  logic signed [ACC_W-1:0]      acc_sat;

  // Clamp the count and left-align the oldest sample at the top
  assign cnt          = (valid_bits > CNT_W'(QUEUE_BITS)) ? CNT_W'(QUEUE_BITS) : valid_bits;
  assign cnt_half     = cnt >> 1;
  assign windows_next = (cnt >= CNT_W'(4)) ? WIN_W'(cnt_half - CNT_W'(1)) : '0;
  assign queue_next   = sample_queue << (CNT_W'(QUEUE_BITS) - cnt);

  // Current window and saturated accumulator update
  assign win     = queue[QUEUE_BITS-1 -: 4];
  assign acc_sum = (ACC_W+1)'(acc) + (ACC_W+1)'(step_lut(win));
  always_comb begin
    if (acc_sum > (ACC_W+1)'(2**(ACC_W-1) - 1)) begin
      acc_sat = ACC_W'(2**(ACC_W-1) - 1);
    end else if (acc_sum < -(ACC_W+1)'(2**(ACC_W-1))) begin
      acc_sat = ACC_W'(-(2**(ACC_W-1)));
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
  end

  assign status.walk_done = (windows == '0);

  // Walk state: load the frame, then advance one window per step
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.step) begin
      if (win[1:0] == REST_PAIR) begin
        acc <= '0;
      end else begin
        acc <= acc_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      queue   <= queue_next;
      windows <= windows_next;
      delta   <= '0;
    end else if (cmd.step) begin
      queue   <= queue << 2;
      windows <= windows - WIN_W'(1);
      if (win[1:0] == REST_PAIR) begin
        delta <= (acc_sat > 0) ? delta + DELTA_W'(1) : delta - DELTA_W'(1);
      end
    end
  end

  // Track the pushbutton level and how long each level held
  always_ff @(posedge clk) begin
    if (rst) begin
      level_reg          <= 1'b0;
      prior_level_reg    <= 1'b0;
      hold_counter       <= '0;
      prior_hold_counter <= '0;
    end else if (cmd.load) begin
      if (push_level != level_reg) begin
        prior_level_reg    <= level_reg;
        level_reg          <= push_level;
        prior_hold_counter <= hold_counter;
        hold_counter       <= '0;
      end else if (hold_counter != '1) begin
        hold_counter <= hold_counter + HOLD_WIDTH'(1);
      end
    end
  end

  // Capture the frame result into the output register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      detent_delta      <= delta;
      push_now          <= level_reg;
      push_before       <= prior_level_reg;
      hold_frames       <= HOLD_OUT_W'(hold_counter);
      prior_hold_frames <= HOLD_OUT_W'(prior_hold_counter);
    end
  end

endmodule

// ===== design/quadrature_encoder_queue_decoder_core.sv =====
// Quadrature encoder queue decoder with pushbutton tracker (top level).
// A request is taken in idle, then its W windows are walked and the result published, W = windows
// in the frame (up to 31 for a full 64-bit queue); one window per cycle on one adder.
// A new request is stalled until the walk ends; the output register lets the next
// request enter while a result waits. Sync reset clears accumulator and tracker.
module quadrature_encoder_queue_decoder_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [qeqd_pkg::QUEUE_BITS-1:0]      sample_queue,
  input  logic [qeqd_pkg::CNT_W-1:0]           valid_bits,
  input  logic                                 push_level,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [qeqd_pkg::DELTA_W-1:0]  detent_delta,
  output logic                                 push_now,
  output logic                                 push_before,
  output logic [qeqd_pkg::HOLD_OUT_W-1:0]      hold_frames,
  output logic [qeqd_pkg::HOLD_OUT_W-1:0]      prior_hold_frames
);
  import qeqd_pkg::*;

  qeqd_cmd_t    cmd;
  qeqd_status_t status;

  // Sequencer
  qeqd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Window walker, button tracker and output register
  qeqd_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .sample_queue      (sample_queue),
    .valid_bits        (valid_bits),
    .push_level        (push_level),
    .detent_delta      (detent_delta),
    .push_now          (push_now),
    .push_before       (push_before),
    .hold_frames       (hold_frames),
    .prior_hold_frames (prior_hold_frames)
  );

endmodule

// ===== tb/qeqd_frame_checker.sv =====
`timescale 1ns / 1ps
// Frame checker for the quadrature encoder queue decoder: watches the request and result
// channels, predicts each frame's result and compares it with the block's output.
// Depends on qeqd_pkg for field widths and the detent rest pair.
module qeqd_frame_checker
  import qeqd_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [QUEUE_BITS-1:0]       sample_queue,
  input  logic [CNT_W-1:0]            valid_bits,
  input  logic                        push_level,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic signed [DELTA_W-1:0]   detent_delta,
  input  logic                        push_now,
  input  logic                        push_before,
  input  logic [HOLD_OUT_W-1:0]       hold_frames,
  input  logic [HOLD_OUT_W-1:0]       prior_hold_frames,
  output int                          mismatches,
  output int                          pending,
  output int                          frames_checked
);

  typedef struct {
    logic signed [DELTA_W-1:0] delta;
    logic                      level_now;
    logic                      level_before;
    logic [HOLD_OUT_W-1:0]     hold;
    logic [HOLD_OUT_W-1:0]     prior_hold;
  } frame_result_t;

  // Decoder and button tracker state, mirrored from the block
  int                    step_sum;
  logic                  level_q;
  logic                  prior_level_q;
  logic [HOLD_WIDTH-1:0] hold_q;
  logic [HOLD_WIDTH-1:0] prior_hold_q;

  frame_result_t expected_frames[$];

  // Quadrature transition weight for a {old pair, new pair} window
  function automatic int transition_step(input logic [3:0] win);
    case (win)
      4'h1, 4'h7, 4'h8, 4'hE: return -1;
      4'h2, 4'h4, 4'hB, 4'hD: return 1;
      default:                return 0;
    endcase
  endfunction

  task automatic predict_frame(input logic [QUEUE_BITS-1:0] queue,
                               input int unsigned count_in, input logic level,
                               output frame_result_t res);
    int         count;
    int         delta;
    logic [3:0] win;
    // Button: swap into the prior slot on a change, else count held frames
    if (level != level_q) begin
      prior_level_q = level_q;
      level_q       = level;
      prior_hold_q  = hold_q;
      hold_q        = '0;
    end else if (hold_q != '1) begin
      hold_q = hold_q + 1'b1;
    end
    // Encoder: walk 4-bit windows from the oldest end, two bits per step
    count = (count_in > QUEUE_BITS) ? QUEUE_BITS : count_in;
    delta = 0;
    while (count > 3) begin
      win      = queue[count-1 -: 4];
      step_sum = step_sum + transition_step(win);
      if (step_sum > 127) step_sum = 127;
      if (step_sum < -128) step_sum = -128;
      count = count - 2;
      if (win[1:0] == REST_PAIR) begin
        delta    = delta + ((step_sum > 0) ? 1 : -1);
        step_sum = 0;
      end
    end
    res.delta        = delta[DELTA_W-1:0];
    res.level_now    = level_q;
    res.level_before = prior_level_q;
    res.hold         = hold_q[HOLD_OUT_W-1:0];
    res.prior_hold   = prior_hold_q[HOLD_OUT_W-1:0];
  endtask

  task automatic compare_field(input string fname, input logic signed [63:0] exp_v,
                               input logic signed [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches = mismatches + 1;
      if (mismatches <= 10)
        $display("mismatch: result %0d field %s expected %0d got %0d",
                 frames_checked, fname, exp_v, act_v);
    end
  endtask

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin : watch
    frame_result_t res;
    frame_result_t exp_res;
    if (rst) begin
      step_sum      = 0;
      level_q       = 1'b0;
      prior_level_q = 1'b0;
      hold_q        = '0;
      prior_hold_q  = '0;
      expected_frames.delete();
    end else begin
      if (in_valid && !in_stall) begin
        predict_frame(sample_queue, int'(valid_bits), push_level, res);
        expected_frames.push_back(res);
      end
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: result with no request outstanding, delta %0d",
                     detent_delta);
        end else begin
          exp_res = expected_frames.pop_front();
          compare_field("detent_delta", 64'(exp_res.delta), 64'(detent_delta));
          compare_field("push_now", {63'd0, exp_res.level_now}, {63'd0, push_now});
          compare_field("push_before", {63'd0, exp_res.level_before},
                        {63'd0, push_before});
          compare_field("hold_frames", {48'd0, exp_res.hold}, {48'd0, hold_frames});
          compare_field("prior_hold_frames", {48'd0, exp_res.prior_hold},
                        {48'd0, prior_hold_frames});
          frames_checked = frames_checked + 1;
        end
      end
    end
    pending = expected_frames.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the quadrature decoder testbench: clock, reset, request stimulus and
// receiver stalls; depends on qeqd_pkg, the core and qeqd_frame_checker.
module testbench;
  import qeqd_pkg::*;

  localparam int HOLDOFF_CYCLES = 300;
  localparam int HOLD_FRAMES    = 40;
  localparam int TAIL_CYCLES    = 40;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [QUEUE_BITS-1:0]     sample_queue = '0;
  logic [CNT_W-1:0]          valid_bits = '0;
  logic                      push_level = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [DELTA_W-1:0] detent_delta;
  logic                      push_now;
  logic                      push_before;
  logic [HOLD_OUT_W-1:0]     hold_frames;
  logic [HOLD_OUT_W-1:0]     prior_hold_frames;

  int   mismatches;
  int   pending;
  int   frames_checked;
  int   frames_sent = 0;
  logic tx_idle_on = 1'b0;
  logic rx_idle_on = 1'b0;
  logic holdoff_req = 1'b0;
  logic holdoff_done = 1'b0;
  logic button = 1'b0;
  logic [1:0] enc_pair = 2'b11;

  quadrature_encoder_queue_decoder_core u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .sample_queue     (sample_queue),
    .valid_bits       (valid_bits),
    .push_level       (push_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .detent_delta     (detent_delta),
    .push_now         (push_now),
    .push_before      (push_before),
    .hold_frames      (hold_frames),
    .prior_hold_frames(prior_hold_frames)
  );

  qeqd_frame_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .sample_queue     (sample_queue),
    .valid_bits       (valid_bits),
    .push_level       (push_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .detent_delta     (detent_delta),
    .push_now         (push_now),
    .push_before      (push_before),
    .hold_frames      (hold_frames),
    .prior_hold_frames(prior_hold_frames),
    .mismatches       (mismatches),
    .pending          (pending),
    .frames_checked   (frames_checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (holdoff_req && !holdoff_done) begin
        out_stall <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
        holdoff_done = 1'b1;
      end
      out_stall <= rx_idle_on && ($urandom_range(99) < 22);
    end
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // Next B,A pair one quadrature step forward or backward
  function automatic logic [1:0] next_pair(input logic [1:0] pair, input int dir);
    if (dir > 0) begin
      case (pair)
        2'b00:   return 2'b10;
        2'b10:   return 2'b11;
        2'b11:   return 2'b01;
        default: return 2'b00;
      endcase
    end else begin
      case (pair)
        2'b00:   return 2'b01;
        2'b01:   return 2'b11;
        2'b11:   return 2'b10;
        default: return 2'b00;
      endcase
    end
  endfunction

  // Shift encoder pairs into the low end of the queue, newest lowest
  task automatic walk_queue(input int pairs, input int dir, input bit wobble,
                            inout logic [QUEUE_BITS-1:0] queue);
    int r;
    for (int i = 0; i < pairs; i++) begin
      r = $urandom_range(99);
      if (!wobble) begin
        enc_pair = next_pair(enc_pair, dir);
      end else if (r < 3) begin
        enc_pair = 2'($urandom_range(3));
      end else if (r >= 28) begin
        enc_pair = next_pair(enc_pair, (r < 92) ? dir : -dir);
      end
      queue = {queue[QUEUE_BITS-3:0], enc_pair};
    end
  endtask

  task automatic send_frame(input logic [QUEUE_BITS-1:0] queue,
                            input logic [CNT_W-1:0] count, input logic level);
    @(negedge clk);
    while (tx_idle_on && ($urandom_range(99) < 22)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    sample_queue <= queue;
    valid_bits   <= count;
    push_level   <= level;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frames_sent = frames_sent + 1;
  endtask

  // Drop the request and hold until every expected result is back
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic random_frame(output logic [QUEUE_BITS-1:0] queue,
                              output logic [CNT_W-1:0] count);
    int kind;
    int pairs;
    queue = {$urandom, $urandom};
    kind  = $urandom_range(99);
    if (kind < 75) begin
      // Noisy rotation, mostly short frames
      pairs = ($urandom_range(99) < 70) ? $urandom_range(2, 8) : $urandom_range(9, 32);
      walk_queue(pairs, $urandom_range(1) ? 1 : -1, 1'b1, queue);
      count = CNT_W'(2 * pairs);
      if (pairs < 32 && $urandom_range(99) < 10) begin
        queue = {queue[QUEUE_BITS-2:0], 1'($urandom_range(1))};
        count = count + 1'b1;
      end
    end else if (kind < 85) begin
      count = CNT_W'($urandom_range(0, 5));
    end else if (kind < 93) begin
      walk_queue(32, $urandom_range(1) ? 1 : -1, 1'b1, queue);
      count = CNT_W'($urandom_range(65, 127));
    end else begin
      count = CNT_W'($urandom_range(0, 64));
    end
  endtask

  task automatic run_random(input int n);
    logic [QUEUE_BITS-1:0] queue;
    logic [CNT_W-1:0]      count;
    repeat (n) begin
      random_frame(queue, count);
      if ($urandom_range(99) < 8) button = ~button;
      send_frame(queue, count, button);
    end
  endtask

  initial begin : stimulus
    logic [QUEUE_BITS-1:0] queue;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty and short queues, extremes, clean rotations, clamping
    send_frame('0, 7'd0, 1'b0);
    send_frame('1, 7'd3, 1'b0);
    send_frame(64'h3, 7'd4, 1'b1);
    send_frame('0, 7'd64, 1'b1);
    send_frame('1, 7'd64, 1'b1);
    send_frame(64'hAAAA_AAAA_AAAA_AAAA, 7'd64, 1'b0);
    send_frame(64'h5555_5555_5555_5555, 7'd64, 1'b0);
    queue = '0;
    walk_queue(32, 1, 1'b0, queue);
    send_frame(queue, 7'd64, 1'b1);
    walk_queue(32, -1, 1'b0, queue);
    send_frame(queue, 7'd64, 1'b1);
    walk_queue(16, 1, 1'b0, queue);
    send_frame({queue[QUEUE_BITS-2:0], 1'b1}, 7'd33, 1'b0);
    walk_queue(32, 1, 1'b0, queue);
    send_frame(queue, 7'd127, 1'b0);
    walk_queue(32, -1, 1'b0, queue);
    send_frame(queue, 7'd65, 1'b1);
    send_frame({$urandom, $urandom}, 7'd127, 1'b1);
    send_frame(64'h8000_0000_0000_0000, 7'd64, 1'b0);
    send_frame(64'hF, 7'd5, 1'b0);
    send_frame('1, 7'd63, 1'b1);
    drain();

    // Random frames with idling on both sides
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_random(500);

    // A stretch with no idling at all
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random(300);

    // Receiver holds off while requests keep coming, then a full pause
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    holdoff_req = 1'b1;
    run_random(40);
    drain();
    run_random(660);

    // Hold the button level for a stretch of frames, then flip it
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (HOLD_FRAMES) send_frame({$urandom, $urandom}, CNT_W'($urandom_range(0, 3)), button);
    button = ~button;
    send_frame('1, 7'd64, button);
    send_frame('0, 7'd2, button);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("summary: %0d frames sent: edge queues, clean and noisy rotations, hold-off,",
             frames_sent);
    $display("summary: button hold and release; %0d results compared, %0d mismatches",
             frames_checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
